[sv/hds_pkg.sv]
// hds_pkg: shared sizes, configuration register codes and stage control type
// for the 2x2 box downscaler; no dependencies
package hds_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_ROWS   = 2048;
	localparam int LINE_DEPTH = MAX_WIDTH / 4;
	localparam int MAX_GROUPS = MAX_WIDTH / 8;

	localparam int PIX_W    = 8;
	localparam int WORD_W   = 4 * PIX_W;
	localparam int PAIR_W   = PIX_W + 1;
	localparam int LINE_W   = 2 * PAIR_W;
	localparam int COL_W    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int GROUP_W  = 9;
	localparam int ROWCNT_W = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = ROWCNT_W;

	// working widths for the saturated register values
	localparam int GCALC_W = ((GROUP_W > COL_W) ? GROUP_W : COL_W) + 2;
	localparam int RCALC_W = ((ROWCNT_W > ROW_W) ? ROWCNT_W : ROW_W) + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GROUP_COUNT = 2'd0,
		CFG_ROW_COUNT   = 2'd1
	} hds_cfg_idx_t;

	// control that travels with one request into the merge stage
	typedef struct packed {
		logic odd_row;
		logic odd_col;
		logic row_end;
		logic frame_end;
	} hds_ctl_t;

endpackage

[sv/hds_line_buf.sv]
// hds_line_buf: single-port line memory holding the even-row pair sums
// depends on hds_pkg
module hds_line_buf import hds_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [COL_W-1:0]  addr,
	input  logic [LINE_W-1:0] wdata,
	output logic [LINE_W-1:0] rdata
);

	logic [LINE_W-1:0] mem_q [LINE_DEPTH];
	logic [LINE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/hds_lane.sv]
// hds_lane: one pixel-pair lane; forms the horizontal pair sum and, one stage
// later, the truncated 2x2 average with the stored pair sum; depends on hds_pkg
module hds_lane import hds_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [PIX_W-1:0]  pix_l,
	input  logic [PIX_W-1:0]  pix_r,
	input  logic [PAIR_W-1:0] prev_sum,
	output logic [PAIR_W-1:0] pair_sum,
	output logic [PIX_W-1:0]  avg
);

	logic [PAIR_W-1:0] pair_s2;
	logic [PAIR_W:0]   box_sum;

	assign pair_sum = {1'b0, pix_l} + {1'b0, pix_r};

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s2 <= pair_sum;
		end
	end

	assign box_sum = {1'b0, pair_s2} + {1'b0, prev_sum};
	assign avg     = box_sum[PAIR_W:2];

endmodule

[sv/hds_merge.sv]
// hds_merge: joins the lane averages of an even and an odd column into one
// output word, holds the result register; depends on hds_pkg
module hds_merge import hds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s2,
	input  hds_ctl_t          ctl_s2,
	input  logic [PIX_W-1:0]  avg_lo,
	input  logic [PIX_W-1:0]  avg_hi,
	output logic              adv,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] out_word,
	output logic              row_end,
	output logic              frame_end
);

	logic                 emit;
	logic [2*PIX_W-1:0]   pending_q;
	logic                 out_valid_q;
	logic [WORD_W-1:0]    out_word_q;
	logic                 row_end_q;
	logic                 frame_end_q;

	assign emit = valid_s2 && ctl_s2.odd_row && ctl_s2.odd_col;
	assign adv  = !emit || !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pending_q   <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s2 && adv && ctl_s2.odd_row) begin
				if (ctl_s2.odd_col) begin
					out_valid_q <= 1'b1;
				end else begin
					pending_q <= {avg_hi, avg_lo};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && adv) begin
			out_word_q  <= {avg_hi, avg_lo, pending_q};
			row_end_q   <= ctl_s2.row_end;
			frame_end_q <= ctl_s2.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule

[sv/image_half_downscale_8bpp_core.sv]
// image_half_downscale_8bpp_core: 2x2 box-average downscaler for 8-bit grey
// raster words; depends on hds_pkg, hds_line_buf, hds_lane, hds_merge
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, pixel_word            | in
//  output  | out_valid, out_ready, out_word, row_end,  | out
//          | frame_end                                 |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// one input request per cycle unless stage 2 waits; a request enters stage 1,
// where the line memory is written (even row) or read (odd row), and reaches the
// merge stage in the next cycle; out_valid rises once the merge stage, holding
// the request completing a result (odd column, odd row), loads the result register
// reset clears the column and row counters, the pending averages and all valids;
// the line memory is not cleared, an entry is only read after it was written
// a stalled output holds the result register; stage 2 only waits when it has
// a result to hand over and the result register is still full
module image_half_downscale_8bpp_core import hds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [WORD_W-1:0]     pixel_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_W-1:0]     out_word,
	output logic                  row_end,
	output logic                  frame_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [GROUP_W-1:0]  group_count_q;
	logic [ROWCNT_W-1:0] row_count_q;

	// position counters
	logic [COL_W-1:0] word_column_q;
	logic [ROW_W-1:0] row_index_q;

	// derived frame geometry
	logic [GCALC_W-1:0] groups;
	logic [GCALC_W-1:0] last_col_w;
	logic [COL_W-1:0]   last_col;
	logic [RCALC_W-1:0] rows;
	logic [RCALC_W-1:0] pair_rows;
	logic [RCALC_W-1:0] row_inc;
	logic               row_done;
	logic               in_fire;
	hds_ctl_t           ctl_s1;

	// stage 2
	logic     valid_s2;
	hds_ctl_t ctl_s2;
	logic     adv;

	// lanes and line memory
	logic [PAIR_W-1:0] pair_lo, pair_hi;
	logic [LINE_W-1:0] line_rdata;
	logic [PIX_W-1:0]  avg_lo, avg_hi;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q <= GROUP_W'(80);
			row_count_q   <= ROWCNT_W'(480);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GROUP_COUNT: group_count_q <= cfg_data[GROUP_W-1:0];
				CFG_ROW_COUNT:   row_count_q   <= cfg_data[ROWCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// group count of zero acts as one, large values saturate to the line size
	always_comb begin
		groups = GCALC_W'(group_count_q);
		if (group_count_q == '0) begin
			groups = GCALC_W'(1);
		end else if (GCALC_W'(group_count_q) > GCALC_W'(MAX_GROUPS)) begin
			groups = GCALC_W'(MAX_GROUPS);
		end
		rows = RCALC_W'(row_count_q);
		if (RCALC_W'(row_count_q) > RCALC_W'(MAX_ROWS)) begin
			rows = RCALC_W'(MAX_ROWS);
		end
	end

	assign last_col_w = (groups << 1) - GCALC_W'(1);
	assign last_col   = last_col_w[COL_W-1:0];
	assign pair_rows  = {rows[RCALC_W-1:1], 1'b0};
	assign row_inc    = RCALC_W'(row_index_q) + RCALC_W'(1);
	assign row_done   = word_column_q >= last_col;

	assign ctl_s1.odd_row   = row_index_q[0];
	assign ctl_s1.odd_col   = word_column_q[0];
	assign ctl_s1.row_end   = row_done;
	assign ctl_s1.frame_end = row_done && (row_inc == pair_rows);

	assign in_ready = !valid_s2 || adv;
	assign in_fire  = in_valid && in_ready;

	// position tracking; a shrunk register value ends the row or frame early
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_column_q <= '0;
			row_index_q   <= '0;
		end else if (in_fire) begin
			if (row_done) begin
				word_column_q <= '0;
				if (row_inc >= rows) begin
					row_index_q <= '0;
				end else begin
					row_index_q <= row_inc[ROW_W-1:0];
				end
			end else begin
				word_column_q <= word_column_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_fire) begin
			valid_s2 <= 1'b1;
		end else if (adv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ctl_s2 <= ctl_s1;
		end
	end

	hds_lane u_lane_lo (
		.clk      (clk),
		.en       (in_fire),
		.pix_l    (pixel_word[PIX_W-1:0]),
		.pix_r    (pixel_word[2*PIX_W-1:PIX_W]),
		.prev_sum (line_rdata[PAIR_W-1:0]),
		.pair_sum (pair_lo),
		.avg      (avg_lo)
	);

	hds_lane u_lane_hi (
		.clk      (clk),
		.en       (in_fire),
		.pix_l    (pixel_word[3*PIX_W-1:2*PIX_W]),
		.pix_r    (pixel_word[4*PIX_W-1:3*PIX_W]),
		.prev_sum (line_rdata[LINE_W-1:PAIR_W]),
		.pair_sum (pair_hi),
		.avg      (avg_hi)
	);

	// even rows write pair sums, odd rows read them back for the lanes
	hds_line_buf u_line_buf (
		.clk   (clk),
		.we    (in_fire && !row_index_q[0]),
		.re    (in_fire && row_index_q[0]),
		.addr  (word_column_q),
		.wdata ({pair_hi, pair_lo}),
		.rdata (line_rdata)
	);

	hds_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.ctl_s2    (ctl_s2),
		.avg_lo    (avg_lo),
		.avg_hi    (avg_hi),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

endmodule

[sv/hds_port_chk.sv]
// hds_port_chk: port-level checks for the downscaler and the bind that
// attaches them; depends on hds_pkg and image_half_downscale_8bpp_core
module hds_port_chk import hds_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] out_word,
	input logic              row_end,
	input logic              frame_end
);

	// the last word of a frame always closes a row
	a_frame_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!frame_end || row_end))
		else $error("frame_end without row_end");

	// input only backs up behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a blocked result");

	// a fresh result follows an accepted source request
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a source request");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_word)
			&& $stable(row_end) && $stable(frame_end)))
		else $error("stalled result changed");

endmodule

bind image_half_downscale_8bpp_core hds_port_chk u_hds_port_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word),
	.row_end   (row_end),
	.frame_end (frame_end)
);
